// ----- rtl/sjpg_pkg.sv -----
`default_nettype none

package sjpg_pkg;

   // Storage widths of the step counter and the phase timer.
   localparam int STEP_COUNT_BITS = 16;
   localparam int TIMER_BITS      = 16;

   // Fixed field and register widths.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int TICKS_W     = 16;
   localparam int MOVE_W      = 16;
   localparam int THRESH_W    = 15;
   localparam int STICK_W     = 16;
   localparam int STEPS_OUT_W = 16;

   // Saturation limits, computed one bit wider than the widest case.
   localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;
   localparam logic [32:0] STEP_MAX  = (33'd1 << STEP_COUNT_BITS) - 33'd1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVE_STEPS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_THRESHOLD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEUTRAL_DEADZONE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_HIGH_TICKS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD_TICKS = 3'd5;

   // Command front end and item kinds.
   localparam logic MODE_JOG    = 1'b0;
   localparam logic MODE_TOGGLE = 1'b1;
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_HIGH = 3'b010,
      PHASE_LOW  = 3'b100
   } sjpg_phase_type;

   typedef enum logic [2:0] {
      JOG_NEUTRAL = 3'b001,
      JOG_RIGHT   = 3'b010,
      JOG_LEFT    = 3'b100
   } sjpg_jog_type;

   typedef struct packed {
      logic                command_mode;
      logic [MOVE_W-1:0]   move_steps;
      logic [THRESH_W-1:0] press_threshold;
      logic [THRESH_W-1:0] neutral_deadzone;
      logic [TICKS_W-1:0]  pulse_high_ticks;
      logic [TICKS_W-1:0]  step_period_ticks;
   } sjpg_cfg_type;

   typedef struct packed {
      logic                   step_level;
      logic                   dir_level;
      logic                   axis_busy;
      logic                   move_started;
      logic [STEPS_OUT_W-1:0] steps_remaining;
   } sjpg_result_type;

   // Phase length clipped to what the timer can hold.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [TICKS_W-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > TIMER_MAX) begin
         return {TIMER_BITS{1'b1}};
      end
      return TIMER_BITS'(v);
   endfunction

   // Move length clipped to what the step counter can hold.
   function automatic logic [STEP_COUNT_BITS-1:0] step_load(input logic [MOVE_W-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      if (wide > STEP_MAX) begin
         return {STEP_COUNT_BITS{1'b1}};
      end
      return STEP_COUNT_BITS'(v);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sjpg_regs.sv -----
`default_nettype none

module sjpg_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [sjpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sjpg_pkg::CSR_DATA_W-1:0]   csr_data,
   output sjpg_pkg::sjpg_cfg_type                 cfg
);
   import sjpg_pkg::*;

   sjpg_cfg_type cfg_ff;
   sjpg_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMMAND_MODE:      cfg_in.command_mode      = csr_data[0];
            CSR_MOVE_STEPS:        cfg_in.move_steps        = MOVE_W'(csr_data);
            CSR_PRESS_THRESHOLD:   cfg_in.press_threshold   = THRESH_W'(csr_data);
            CSR_NEUTRAL_DEADZONE:  cfg_in.neutral_deadzone  = THRESH_W'(csr_data);
            CSR_PULSE_HIGH_TICKS:  cfg_in.pulse_high_ticks  = TICKS_W'(csr_data);
            CSR_STEP_PERIOD_TICKS: cfg_in.step_period_ticks = TICKS_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_mode      <= MODE_JOG;
         cfg_ff.move_steps        <= MOVE_W'(20);
         cfg_ff.press_threshold   <= THRESH_W'(128);
         cfg_ff.neutral_deadzone  <= THRESH_W'(26);
         cfg_ff.pulse_high_ticks  <= TICKS_W'(10);
         cfg_ff.step_period_ticks <= TICKS_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/sjpg_axis.sv -----
`default_nettype none

module sjpg_axis (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sjpg_pkg::sjpg_cfg_type                cfg,
   input  wire logic                                  process_en,
   input  wire logic                                  func,
   input  wire logic signed [sjpg_pkg::STICK_W-1:0]   stick_value,
   output sjpg_pkg::sjpg_result_type                  result
);
   import sjpg_pkg::*;

   logic [STEP_COUNT_BITS-1:0] remaining_ff, remaining_in;
   sjpg_phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0]      countdown_ff, countdown_in;
   logic                       dir_ff, dir_in;
   sjpg_jog_type               jog_ff, jog_in;
   logic                       toggle_up_ff, toggle_up_in;
   logic                       pressed_ff, pressed_in;

   logic signed [STICK_W:0]    z;
   logic signed [STICK_W:0]    thr_pos;
   logic signed [STICK_W:0]    thr_neg;
   logic [STICK_W:0]           mag;
   logic                       pressed;
   logic                       busy;
   logic [TICKS_W-1:0]         low_ticks;
   logic [STEP_COUNT_BITS-1:0] move_len;
   logic                       queue;
   logic                       queue_dir;
   logic                       started;

   always_comb begin
      z        = {stick_value[STICK_W-1], stick_value};
      thr_pos  = $signed({2'b00, cfg.press_threshold});
      thr_neg  = -thr_pos;
      mag      = z[STICK_W] ? $unsigned(-z) : $unsigned(z);
      pressed  = mag > {2'b00, cfg.press_threshold};
      busy     = (remaining_ff != '0) || (phase_ff != PHASE_IDLE);
      low_ticks = (cfg.step_period_ticks > cfg.pulse_high_ticks)
                ? cfg.step_period_ticks - cfg.pulse_high_ticks : TICKS_W'(1);
      move_len = step_load(cfg.move_steps);
   end

   always_comb begin
      remaining_in = remaining_ff;
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      dir_in       = dir_ff;
      jog_in       = jog_ff;
      toggle_up_in = toggle_up_ff;
      pressed_in   = pressed_ff;
      queue        = 1'b0;
      queue_dir    = 1'b0;
      started      = 1'b0;

      if (func == FUNC_TICK) begin
         if (remaining_ff == '0) begin
            phase_in = PHASE_IDLE;
         end else begin
            unique case (phase_ff)
               PHASE_HIGH, PHASE_LOW: begin
                  if (countdown_ff > TIMER_BITS'(1)) begin
                     countdown_in = countdown_ff - TIMER_BITS'(1);
                  end else if (phase_ff == PHASE_HIGH) begin
                     phase_in     = PHASE_LOW;
                     countdown_in = timer_load(low_ticks);
                  end else begin
                     remaining_in = remaining_ff - STEP_COUNT_BITS'(1);
                     if (remaining_ff != STEP_COUNT_BITS'(1)) begin
                        phase_in     = PHASE_HIGH;
                        countdown_in = timer_load(cfg.pulse_high_ticks);
                     end else begin
                        phase_in     = PHASE_IDLE;
                        countdown_in = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end else if (cfg.command_mode == MODE_JOG) begin
         // Each direction fires once, then rearms from the deadzone or when the other one fires.
         if (z > thr_pos && jog_ff != JOG_RIGHT && !busy) begin
            queue     = 1'b1;
            queue_dir = 1'b1;
            jog_in    = JOG_RIGHT;
         end else if (z < thr_neg && jog_ff != JOG_LEFT && !busy) begin
            queue     = 1'b1;
            queue_dir = 1'b0;
            jog_in    = JOG_LEFT;
         end else if (mag < {2'b00, cfg.neutral_deadzone}) begin
            jog_in    = JOG_NEUTRAL;
         end
      end else begin
         if (pressed && !pressed_ff && !busy) begin
            queue        = 1'b1;
            queue_dir    = !toggle_up_ff;
            toggle_up_in = !toggle_up_ff;
            dir_in       = !toggle_up_ff;
         end
         pressed_in = pressed;
      end

      // A move only starts from an idle axis, so the counter is loaded directly.
      if (queue && move_len != '0) begin
         started      = 1'b1;
         dir_in       = queue_dir;
         remaining_in = move_len;
         phase_in     = PHASE_HIGH;
         countdown_in = timer_load(cfg.pulse_high_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         phase_ff     <= PHASE_IDLE;
         countdown_ff <= '0;
         dir_ff       <= 1'b0;
         jog_ff       <= JOG_NEUTRAL;
         toggle_up_ff <= 1'b0;
         pressed_ff   <= 1'b0;
      end else if (process_en) begin
         remaining_ff <= remaining_in;
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         dir_ff       <= dir_in;
         jog_ff       <= jog_in;
         toggle_up_ff <= toggle_up_in;
         pressed_ff   <= pressed_in;
      end
   end

   always_comb begin
      result.step_level      = (phase_in == PHASE_HIGH);
      result.dir_level       = dir_in;
      result.axis_busy       = (remaining_in != '0) || (phase_in != PHASE_IDLE);
      result.move_started    = started;
      result.steps_remaining = STEPS_OUT_W'(remaining_in);
   end

endmodule

`default_nettype wire

// ----- rtl/stepper_jog_pulse_generator.sv -----
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------
// request   | req_valid/req_ready  | req_func, req_stick_value
// response  | rsp_valid/rsp_ready  | rsp_step_level, rsp_dir_level, rsp_axis_busy,
//           |                      | rsp_move_started, rsp_steps_remaining
// csr write | csr_write_enable     | csr_index, csr_data
//
// One item per cycle sustained while responses are taken; each item passes through
// the input register, then the axis update into the response register.
// Reset is synchronous and clears the axis state and loads default settings.
// A stalled response holds the response register; the input register then fills
// and req_ready drops until the response is taken. No clearing pass is needed.

module stepper_jog_pulse_generator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output wire logic                                  req_ready,
   input  wire logic                                  req_func,
   input  wire logic signed [sjpg_pkg::STICK_W-1:0]   req_stick_value,
   output wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output wire logic                                  rsp_step_level,
   output wire logic                                  rsp_dir_level,
   output wire logic                                  rsp_axis_busy,
   output wire logic                                  rsp_move_started,
   output wire logic [sjpg_pkg::STEPS_OUT_W-1:0]      rsp_steps_remaining,
   input  wire logic                                  csr_write_enable,
   input  wire logic [sjpg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [sjpg_pkg::CSR_DATA_W-1:0]       csr_data
);
   import sjpg_pkg::*;

   sjpg_cfg_type    cfg;
   sjpg_result_type axis_result;

   // Input register: holds one accepted item until the axis can process it.
   logic                       in_valid_ff, in_valid_in;
   logic                       in_func_ff;
   logic signed [STICK_W-1:0]  in_stick_ff;

   // Response register: holds the result of the last processed item.
   logic                       out_valid_ff, out_valid_in;
   sjpg_result_type            out_ff;

   logic accept;
   logic advance;

   // The axis state moves forward only when its result has a place to go.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff  <= req_func;
         in_stick_ff <= req_stick_value;
      end
      if (advance) begin
         out_ff <= axis_result;
      end
   end

   sjpg_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   sjpg_axis u_axis (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .process_en  (advance),
      .func        (in_func_ff),
      .stick_value (in_stick_ff),
      .result      (axis_result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_step_level      = out_ff.step_level;
   assign rsp_dir_level       = out_ff.dir_level;
   assign rsp_axis_busy       = out_ff.axis_busy;
   assign rsp_move_started    = out_ff.move_started;
   assign rsp_steps_remaining = out_ff.steps_remaining;

`ifndef SYNTH
   // A freshly started move is always busy, in its high phase, with steps left.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_started |->
         rsp_axis_busy && rsp_step_level && (rsp_steps_remaining != '0))
      else $error("move started without a busy axis in its high phase");

   // The STEP line is only high while the axis is busy.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_level |-> rsp_axis_busy)
      else $error("STEP high on an idle axis");

   // With both registers full and the response stalled, no new item may enter.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && in_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input register overrun while the response is stalled");

   // A processed item always lands in the response register on the next edge.
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item did not produce a response");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import sjpg_pkg::*;

   // Longest stretch without a handshake on either channel before the run is declared hung.
   // The slowest correct run stalls for the deliberate hold-off below plus a
   // long random gap on each side.
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_ITEMS    = 1000;

   // Register indexes past the last one the block decodes; writes there are dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic              func;
      logic [STICK_W-1:0] stick;
   } stick_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_func = FUNC_TICK;
   logic signed [STICK_W-1:0]  req_stick_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_step_level;
   logic                       rsp_dir_level;
   logic                       rsp_axis_busy;
   logic                       rsp_move_started;
   logic [STEPS_OUT_W-1:0]     rsp_steps_remaining;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   stepper_jog_pulse_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_stick_value     (req_stick_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_step_level      (rsp_step_level),
      .rsp_dir_level       (rsp_dir_level),
      .rsp_axis_busy       (rsp_axis_busy),
      .rsp_move_started    (rsp_move_started),
      .rsp_steps_remaining (rsp_steps_remaining),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the axis: settings plus every piece of state that the
   // block keeps. It is advanced once per accepted item, in acceptance order.
   sjpg_cfg_type    axis_cfg;
   logic [15:0]     axis_remaining;
   sjpg_phase_type  axis_phase;
   logic [15:0]     axis_countdown;
   logic            axis_dir;
   sjpg_jog_type    axis_jog;
   logic            axis_next_up;
   logic            axis_prev_pressed;

   // Items waiting for the driver, and results owed by the block.
   stick_item_type  pending_items[$];
   sjpg_result_type axis_results_due[$];
   stick_item_type  next_item;
   sjpg_result_type due_result;

   int   items_queued = 0;
   int   items_accepted = 0;
   int   results_seen = 0;
   int   moves_started = 0;
   int   settings_applied = 0;
   int   error_count = 0;
   int   send_gap_left = 0;
   int   stall_left = 0;
   int   quiet_cycles = 0;
   bit   req_accepted = 1'b0;
   bit   req_idle_enable = 1'b1;
   bit   rsp_idle_enable = 1'b1;
   bit   hold_off_request = 1'b0;

   // Queue a move of move_steps steps. A zero move length queues nothing and
   // leaves the direction alone. The pulse train starts in the high phase
   // only if the axis was idle.
   function automatic logic start_travel(input logic toward_down);
      logic [16:0] total;
      if (axis_cfg.move_steps == '0) begin
         return 1'b0;
      end
      axis_dir = toward_down;
      total = {1'b0, axis_remaining} + {1'b0, axis_cfg.move_steps};
      axis_remaining = total[16] ? 16'hFFFF : total[15:0];
      if (axis_phase == PHASE_IDLE) begin
         axis_phase = PHASE_HIGH;
         axis_countdown = axis_cfg.pulse_high_ticks;
      end
      return 1'b1;
   endfunction

   // One timebase tick. A countdown of zero expires on the next tick just
   // like a countdown of one. The low phase lasts period minus high, but never
   // less than one tick.
   function automatic void advance_one_tick();
      if (axis_remaining == '0) begin
         axis_phase = PHASE_IDLE;
         return;
      end
      if (axis_phase != PHASE_HIGH && axis_phase != PHASE_LOW) begin
         return;
      end
      if (axis_countdown > 16'd1) begin
         axis_countdown = axis_countdown - 16'd1;
         return;
      end
      if (axis_phase == PHASE_HIGH) begin
         axis_phase = PHASE_LOW;
         axis_countdown = (axis_cfg.step_period_ticks > axis_cfg.pulse_high_ticks) ?
                          axis_cfg.step_period_ticks - axis_cfg.pulse_high_ticks : 16'd1;
      end else begin
         axis_remaining = axis_remaining - 16'd1;
         if (axis_remaining != '0) begin
            axis_phase = PHASE_HIGH;
            axis_countdown = axis_cfg.pulse_high_ticks;
         end else begin
            axis_phase = PHASE_IDLE;
            axis_countdown = '0;
         end
      end
   endfunction

   // One joystick sample through whichever front end is selected. The other
   // front end keeps its state untouched.
   function automatic logic take_stick_sample(input logic signed [STICK_W-1:0] stick);
      int   z;
      int   mag;
      int   thr;
      int   dz;
      logic pressed;
      logic started;
      logic idle;
      z = stick;
      mag = (z < 0) ? -z : z;
      thr = int'(axis_cfg.press_threshold);
      dz = int'(axis_cfg.neutral_deadzone);
      started = 1'b0;
      idle = (axis_remaining == '0) && (axis_phase == PHASE_IDLE);
      if (axis_cfg.command_mode == MODE_JOG) begin
         // A direction fires once, then is locked out until the stick has
         // been back inside the deadzone or the other direction has fired. The
         // lock moves even when the move length is zero.
         if (z > thr && axis_jog != JOG_RIGHT && idle) begin
            started = start_travel(1'b1);
            axis_jog = JOG_RIGHT;
         end else if (z < -thr && axis_jog != JOG_LEFT && idle) begin
            started = start_travel(1'b0);
            axis_jog = JOG_LEFT;
         end else if (mag < dz) begin
            axis_jog = JOG_NEUTRAL;
         end
      end else begin
         // Press edges alternate down and up; the direction line follows the
         // toggle even when nothing gets queued.
         pressed = mag > thr;
         if (pressed && !axis_prev_pressed && idle) begin
            axis_dir = ~axis_next_up;
            started = start_travel(~axis_next_up);
            axis_next_up = ~axis_next_up;
         end
         axis_prev_pressed = pressed;
      end
      return started;
   endfunction

   function automatic sjpg_result_type predict_axis_result(
      input logic func, input logic signed [STICK_W-1:0] stick);
      sjpg_result_type r;
      logic started;
      started = 1'b0;
      if (func == FUNC_TICK) begin
         advance_one_tick();
      end else begin
         started = take_stick_sample(stick);
      end
      r.step_level      = (axis_phase == PHASE_HIGH);
      r.dir_level       = axis_dir;
      r.axis_busy       = (axis_remaining != '0) || (axis_phase != PHASE_IDLE);
      r.move_started    = started;
      r.steps_remaining = axis_remaining;
      return r;
   endfunction

   // Gap lengths: mostly none, sometimes short, rarely a long pause.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // A stick value that counts as a command for the current threshold. At the
   // top threshold only full negative deflection gets past it.
   function automatic logic [STICK_W-1:0] stick_past(input int thr);
      int m;
      if (thr >= 32767 || $urandom_range(0, 15) == 0) begin
         return 16'h8000;
      end
      m = $urandom_range(thr + 1, 32767);
      return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
   endfunction

   // A stick value that lets go of the command: inside the deadzone in jog
   // mode, at or below the threshold in toggle mode.
   function automatic logic [STICK_W-1:0] stick_resting();
      int bound;
      int m;
      bound = (axis_cfg.command_mode == MODE_JOG) ? int'(axis_cfg.neutral_deadzone) - 1
                                                  : int'(axis_cfg.press_threshold);
      if (bound < 0) begin
         return '0;
      end
      m = $urandom_range(0, bound);
      return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
   endfunction

   task automatic queue_item(input logic func, input logic [STICK_W-1:0] stick);
      stick_item_type it;
      it.func = func;
      it.stick = stick;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Register writes go to the block and to the shadow copy together. They
   // only happen while no item is in flight.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_COMMAND_MODE:      axis_cfg.command_mode      = value[0];
         CSR_MOVE_STEPS:        axis_cfg.move_steps        = value;
         CSR_PRESS_THRESHOLD:   axis_cfg.press_threshold   = value[THRESH_W-1:0];
         CSR_NEUTRAL_DEADZONE:  axis_cfg.neutral_deadzone  = value[THRESH_W-1:0];
         CSR_PULSE_HIGH_TICKS:  axis_cfg.pulse_high_ticks  = value;
         CSR_STEP_PERIOD_TICKS: axis_cfg.step_period_ticks = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic mode, input logic [15:0] move,
                                 input logic [15:0] thr, input logic [15:0] dz,
                                 input logic [15:0] high, input logic [15:0] period);
      write_reg(CSR_COMMAND_MODE, 16'(mode));
      write_reg(CSR_MOVE_STEPS, move);
      write_reg(CSR_PRESS_THRESHOLD, thr);
      write_reg(CSR_NEUTRAL_DEADZONE, dz);
      write_reg(CSR_PULSE_HIGH_TICKS, high);
      write_reg(CSR_STEP_PERIOD_TICKS, period);
      settings_applied++;
   endtask

   // Wait until every queued item has come back as a result, then let the
   // two-stage pipeline settle before anything else touches the registers.
   task automatic wait_for_drain();
      while (results_seen < items_queued) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   // A mixed run of well-formed command sequences: presses past the
   // threshold, releases, bursts of ticks that walk the pulse train through
   // its phases, and a little noise with random kind and stick value.
   task automatic queue_random_run(input int count, output int done);
      int kind;
      int n;
      done = 0;
      while (done < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 28) begin
            queue_item(FUNC_SAMPLE, stick_past(int'(axis_cfg.press_threshold)));
            done++;
         end else if (kind < 45) begin
            queue_item(FUNC_SAMPLE, stick_resting());
            done++;
         end else if (kind < 88) begin
            n = $urandom_range(1, 12);
            repeat (n) queue_item(FUNC_TICK, 16'($urandom));
            done += n;
         end else begin
            queue_item(1'($urandom_range(0, 1)), 16'($urandom));
            done++;
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Request driver. The payload changes only on the falling edge, and valid
   // stays high with the same payload until the block takes the item.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // Still waiting for the block to take the current item.
      end else if (send_gap_left > 0) begin
         send_gap_left--;
         req_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
         next_item = pending_items.pop_front();
         req_func <= next_item.func;
         req_stick_value <= next_item.stick;
         req_valid <= 1'b1;
         send_gap_left = req_idle_enable ? draw_gap() : 0;
      end else begin
         req_valid <= 1'b0;
      end
      req_accepted = 1'b0;
   end

   // Result receiver. Normally it stalls at random; on request it holds off
   // for a long stretch so the block backs up and drops req_ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_left = HOLD_OFF_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_enable) begin
         stall_left = draw_gap();
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Results are checked before the request side is looked at, so a
   // result and a new item on the same edge never disturb each other.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_move_started) begin
               moves_started++;
            end
            if (axis_results_due.size() == 0) begin
               $error("result arrived with no item outstanding");
               error_count++;
            end else begin
               due_result = axis_results_due.pop_front();
               check_field("step_level", due_result.step_level, rsp_step_level);
               check_field("dir_level", due_result.dir_level, rsp_dir_level);
               check_field("axis_busy", due_result.axis_busy, rsp_axis_busy);
               check_field("move_started", due_result.move_started, rsp_move_started);
               check_field("steps_remaining", due_result.steps_remaining,
                           rsp_steps_remaining);
            end
         end
         if (req_valid && req_ready) begin
            req_accepted = 1'b1;
            items_accepted++;
            axis_results_due.push_back(predict_axis_result(req_func, req_stick_value));
         end
      end
   end

   // Watchdog: any stretch this long with no handshake on either channel
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_index;
      int random_items;
      int done;

      // Shadow state starts at the block's reset values and default settings.
      axis_cfg.command_mode      = MODE_JOG;
      axis_cfg.move_steps        = 16'd20;
      axis_cfg.press_threshold   = 15'd128;
      axis_cfg.neutral_deadzone  = 15'd26;
      axis_cfg.pulse_high_ticks  = 16'd10;
      axis_cfg.step_period_ticks = 16'd1000;
      axis_remaining    = '0;
      axis_phase        = PHASE_IDLE;
      axis_countdown    = '0;
      axis_dir          = 1'b0;
      axis_jog          = JOG_NEUTRAL;
      axis_next_up      = 1'b0;
      axis_prev_pressed = 1'b0;
      random_items = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Default settings straight out of reset: a stick exactly at the
      // threshold is not a command, and a tick on an idle axis does nothing.
      queue_item(FUNC_SAMPLE, 16'd128);
      queue_item(FUNC_SAMPLE, -16'sd128);
      queue_item(FUNC_TICK, 16'hFFFF);
      queue_item(FUNC_SAMPLE, 16'd25);
      wait_for_drain();

      // Writes to undecoded indexes must not disturb any setting.
      write_reg(CSR_SPARE_LOW, 16'hFFFF);
      write_reg(CSR_SPARE_HIGH, 16'h0000);

      // Jog mode with zero high and zero period: each countdown expires on
      // the very next tick. Covers both directions, the edge lockout and the
      // return through the deadzone.
      apply_settings(MODE_JOG, 16'd1, 16'd100, 16'd50, 16'd0, 16'd0);
      queue_item(FUNC_SAMPLE, 16'd101);
      queue_item(FUNC_TICK, 16'h0000);
      queue_item(FUNC_TICK, 16'h7FFF);
      queue_item(FUNC_SAMPLE, 16'h7FFF);
      queue_item(FUNC_SAMPLE, -16'sd49);
      queue_item(FUNC_SAMPLE, 16'h7FFF);
      queue_item(FUNC_TICK, 16'h8000);
      queue_item(FUNC_TICK, 16'h5555);
      queue_item(FUNC_SAMPLE, 16'h8000);
      queue_item(FUNC_TICK, 16'hAAAA);
      queue_item(FUNC_TICK, 16'h0001);
      wait_for_drain();

      // Zero move length in jog mode: the edge memory still moves.
      apply_settings(MODE_JOG, 16'd0, 16'd100, 16'd50, 16'd0, 16'd0);
      queue_item(FUNC_SAMPLE, 16'd101);
      queue_item(FUNC_SAMPLE, 16'd0);
      wait_for_drain();

      // Zero move length in toggle mode: presses still flip the direction.
      apply_settings(MODE_TOGGLE, 16'd0, 16'd100, 16'd50, 16'd2, 16'd1);
      queue_item(FUNC_SAMPLE, 16'd200);
      queue_item(FUNC_SAMPLE, 16'd0);
      queue_item(FUNC_SAMPLE, -16'sd200);
      queue_item(FUNC_SAMPLE, 16'd100);
      wait_for_drain();

      // Toggle mode with a period shorter than the high phase, so the low
      // phase is clamped to one tick. A held press does not retrigger.
      apply_settings(MODE_TOGGLE, 16'd3, 16'd100, 16'd50, 16'd2, 16'd1);
      queue_item(FUNC_SAMPLE, 16'h8000);
      queue_item(FUNC_SAMPLE, 16'h8000);
      repeat (6) queue_item(FUNC_TICK, 16'($urandom));
      wait_for_drain();

      // Random phases, each under its own settings. Some phases run with no
      // idling on one or both sides; one phase makes the receiver hold off for
      // a long time while the sender keeps pushing.
      phase_index = 0;
      while (random_items < RANDOM_ITEMS) begin
         req_idle_enable = (phase_index % 3 != 1);
         rsp_idle_enable = (phase_index % 4 != 2);
         apply_settings(1'($urandom_range(0, 1)),
                        ($urandom_range(0, 9) == 0) ? 16'd0 :
                        ($urandom_range(0, 7) == 0) ? 16'($urandom_range(5, 12)) :
                                                      16'($urandom_range(1, 4)),
                        ($urandom_range(0, 6) == 0) ? 16'd0 :
                        ($urandom_range(0, 9) == 0) ? 16'd32767 :
                        ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767)) :
                                                      16'($urandom_range(1, 3000)),
                        ($urandom_range(0, 6) == 0) ? 16'd0 :
                        ($urandom_range(0, 9) == 0) ? 16'd32767 :
                        ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767)) :
                                                      16'($urandom_range(0, 3000)),
                        16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 8)));
         if (phase_index == 3) begin
            req_idle_enable = 1'b0;
            hold_off_request = 1'b1;
         end
         queue_random_run($urandom_range(60, 140), done);
         random_items += done;
         wait_for_drain();
         phase_index++;
      end

      // Largest settings. First let the axis run dry with the shortest pulse
      // train, then start a full-length move with the longest phases. The
      // top threshold is crossed only by full negative deflection.
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      apply_settings(MODE_JOG, 16'd1, 16'd0, 16'd32767, 16'd0, 16'd0);
      repeat (40) queue_item(FUNC_TICK, 16'($urandom));
      queue_item(FUNC_SAMPLE, 16'd0);
      wait_for_drain();
      apply_settings(MODE_JOG, 16'hFFFF, 16'd0, 16'd32767, 16'hFFFF, 16'hFFFF);
      queue_item(FUNC_SAMPLE, 16'h7FFF);
      repeat (16) queue_item(FUNC_TICK, 16'($urandom));
      queue_item(FUNC_SAMPLE, 16'h8000);
      wait_for_drain();
      apply_settings(MODE_TOGGLE, 16'hFFFF, 16'd32767, 16'd0, 16'hFFFF, 16'd1);
      queue_item(FUNC_SAMPLE, 16'h8000);
      repeat (4) queue_item(FUNC_TICK, 16'($urandom));
      wait_for_drain();

      repeat (8) @(posedge clock);
      if (axis_results_due.size() != 0) begin
         $error("%0d results never arrived", axis_results_due.size());
         error_count++;
      end

      $display("Run covered %0d items under %0d register settings, %0d of them random.",
               items_accepted, settings_applied, random_items);
      $display("Checked %0d results, %0d of which started a move.",
               results_seen, moves_started);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
